FILE: hw/rtl/crg_pkg.sv
// ============================================================================
// crg_pkg - shared definitions for the camera primary ray generator
// Field widths, stage payload types, register indexes and the reciprocal
// square root seed table.
// ============================================================================
`default_nettype none

package crg_pkg;

    // Number of vector lanes (x, y, z).
    localparam int LANES = 3;

    // Newton steps of the reciprocal square root; each step is three stages.
    localparam int RSQRT_ITERATIONS = 3;
    localparam int RS_STAGES        = 3 * RSQRT_ITERATIONS;

    // Datapath widths.
    localparam int COORD_W = 16;  // screen coordinate, Q0.16
    localparam int SCALE_W = 24;  // scale register, Q8.16
    localparam int BASIS_W = 48;  // three packed Q1.14 lanes
    localparam int LANE_W  = 16;  // one basis lane
    localparam int POS_W   = 32;  // position, Q16.16
    localparam int TU_W    = 18;  // 2u - 1 in Q1.16
    localparam int SX_W    = 42;  // screen offset times scale, 32 fraction bits
    localparam int PP_W    = 58;  // lane product and component sum
    localparam int MAG_W   = 57;  // component magnitude
    localparam int BL_W    = 6;   // bit length of a magnitude
    localparam int NORM_W  = 30;  // normalised magnitude
    localparam int SQ_W    = 60;  // square of a normalised magnitude
    localparam int SUM_W   = 62;  // sum of squares
    localparam int MQ_W    = 32;  // Q2.30 mantissa
    localparam int Y_W     = 31;  // Q1.30 reciprocal square root
    localparam int ACC_W   = 32;  // Newton intermediate (square or correction)
    localparam int PROD_W  = 61;  // magnitude times reciprocal root
    localparam int DIR_W   = 16;  // direction, Q1.14

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic signed [TU_W-1:0] ONE_Q1_16  = 18'sd65536;
    localparam logic [BL_W-1:0]        NORM_LEN   = 6'd30;
    localparam logic [ACC_W-1:0]       THREE_Q30  = 32'hC000_0000;
    localparam logic [DIR_W:0]         DIR_LIMIT  = 17'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORWARD = 4'd0,
        REG_RIGHT   = 4'd1,
        REG_UP      = 4'd2,
        REG_SCALE_X = 4'd3,
        REG_SCALE_Y = 4'd4,
        REG_POS_X   = 4'd5,
        REG_POS_Y   = 4'd6,
        REG_POS_Z   = 4'd7
    } cfg_index_t;

    // Camera set-up seen by the front end.
    typedef struct packed {
        logic [BASIS_W-1:0] fwd;
        logic [BASIS_W-1:0] rgt;
        logic [BASIS_W-1:0] up;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
    } cfg_t;

    // Front end to normaliser: signed components as sign and magnitude.
    typedef struct packed {
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][MAG_W-1:0] mag;
    } vec_t;

    // Normaliser through the reciprocal root stages to the output stages.
    typedef struct packed {
        logic [MQ_W-1:0]              mq;
        logic [Y_W-1:0]               y;
        logic [ACC_W-1:0]             acc;
        logic                         h;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][NORM_W-1:0] a;
    } rs_t;

    // One signed Q1.14 lane of a packed basis register.
    function automatic logic signed [LANE_W-1:0] basis_lane(
        input logic [BASIS_W-1:0] b,
        input int unsigned        k
    );
        return signed'(b[LANE_W*k +: LANE_W]);
    endfunction

    // Position of the highest set bit plus one; zero for a zero word.
    function automatic logic [BL_W-1:0] bit_len(input logic [MAG_W-1:0] x);
        logic [BL_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (x[i]) n = BL_W'(i + 1);
        end
        return n;
    endfunction

    // Seed of 1/sqrt(m) in Q0.16 at the midpoint of each segment: eight
    // segments over [1,2) and eight over [2,4).
    function automatic logic [15:0] rsqrt_seed(input logic [3:0] idx);
        logic [15:0] s;
        case (idx)
            4'd0:    s = 16'd63579;
            4'd1:    s = 16'd60140;
            4'd2:    s = 16'd57205;
            4'd3:    s = 16'd54661;
            4'd4:    s = 16'd52429;
            4'd5:    s = 16'd50449;
            4'd6:    s = 16'd48679;
            4'd7:    s = 16'd47082;
            4'd8:    s = 16'd44957;
            4'd9:    s = 16'd42525;
            4'd10:   s = 16'd40450;
            4'd11:   s = 16'd38651;
            4'd12:   s = 16'd37073;
            4'd13:   s = 16'd35673;
            4'd14:   s = 16'd34421;
            4'd15:   s = 16'd33292;
            default: s = 16'd63579;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/crg_front.sv
// ============================================================================
// crg_front - screen offsets and camera basis combination
// Three stages: scaled screen offsets, basis lane products, component sums
// split into sign and magnitude.
// ============================================================================
`default_nettype none

module crg_front
    import crg_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire cfg_t           cfg,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire [COORD_W-1:0]   u_coord,
    input  wire [COORD_W-1:0]   v_coord,
    output logic                out_valid,
    input  wire                 out_ready,
    output vec_t                out_data
);

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // Stage 1: tu = 2u - 1 and tv = 1 - 2v, each times its scale.
    logic signed [TU_W-1:0]   tu, tv;
    logic signed [SX_W:0]     sx_full, sy_full;
    logic signed [SX_W-1:0]   s1_sx_reg, s1_sy_reg;

    assign tu      = signed'({1'b0, u_coord, 1'b0}) - ONE_Q1_16;
    assign tv      = ONE_Q1_16 - signed'({1'b0, v_coord, 1'b0});
    assign sx_full = tu * signed'({1'b0, cfg.scale_x});
    assign sy_full = tv * signed'({1'b0, cfg.scale_y});

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_sx_reg <= sx_full[SX_W-1:0];
            s1_sy_reg <= sy_full[SX_W-1:0];
        end
    end

    // Stage 2: right and up lanes times the offsets.
    logic signed [PP_W-1:0] pr_next [LANES];
    logic signed [PP_W-1:0] pw_next [LANES];
    logic signed [PP_W-1:0] s2_pr_reg [LANES];
    logic signed [PP_W-1:0] s2_pw_reg [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            pr_next[k] = basis_lane(cfg.rgt, k) * s1_sx_reg;
            pw_next[k] = basis_lane(cfg.up, k) * s1_sy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            for (int k = 0; k < LANES; k++) begin
                s2_pr_reg[k] <= pr_next[k];
                s2_pw_reg[k] <= pw_next[k];
            end
        end
    end

    // Stage 3: forward lane shifted to 46 fraction bits plus both products.
    logic signed [PP_W-1:0] c_next [LANES];
    vec_t                   vec_next;
    vec_t                   s3_reg;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            c_next[k]       = (PP_W'(basis_lane(cfg.fwd, k)) <<< 32)
                            + s2_pr_reg[k] + s2_pw_reg[k];
            vec_next.neg[k] = c_next[k][PP_W-1];
            vec_next.mag[k] = c_next[k][PP_W-1] ? MAG_W'(-c_next[k])
                                                : c_next[k][MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) s3_reg <= vec_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/crg_norm.sv
// ============================================================================
// crg_norm - magnitude normalisation and sum of squares
// Four stages: common bit length, shift into [2^29, 2^30), squares, then the
// sum with its Q2.30 mantissa and the table seed of the reciprocal root.
// ============================================================================
`default_nettype none

module crg_norm
    import crg_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire vec_t   in_data,
    output logic        out_valid,
    input  wire         out_ready,
    output rs_t         out_data
);

    logic en4, en5, en6, en7;
    logic v4_reg, v5_reg, v6_reg, v7_reg;

    assign en7      = !v7_reg || out_ready;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (en4) v4_reg <= in_valid;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    // Stage 4: the largest magnitude has the same bit length as the OR of all.
    logic [LANES-1:0][MAG_W-1:0] s4_mag_reg;
    logic [LANES-1:0]            s4_neg_reg;
    logic [BL_W-1:0]             s4_bl_reg;

    always_ff @(posedge aclk) begin
        if (en4) begin
            s4_mag_reg <= in_data.mag;
            s4_neg_reg <= in_data.neg;
            s4_bl_reg  <= bit_len(in_data.mag[0] | in_data.mag[1] | in_data.mag[2]);
        end
    end

    // Stage 5: one common shift; right shifts truncate.
    logic [LANES-1:0][NORM_W-1:0] a_next;
    logic [LANES-1:0][NORM_W-1:0] s5_a_reg;
    logic [LANES-1:0]             s5_neg_reg;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (s4_bl_reg > NORM_LEN) begin
                a_next[k] = NORM_W'(s4_mag_reg[k] >> (s4_bl_reg - NORM_LEN));
            end else begin
                a_next[k] = NORM_W'(s4_mag_reg[k] << (NORM_LEN - s4_bl_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            s5_a_reg   <= a_next;
            s5_neg_reg <= s4_neg_reg;
        end
    end

    // Stage 6: squares.
    logic [LANES-1:0][SQ_W-1:0]   sq_next;
    logic [LANES-1:0][SQ_W-1:0]   s6_sq_reg;
    logic [LANES-1:0][NORM_W-1:0] s6_a_reg;
    logic [LANES-1:0]             s6_neg_reg;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            sq_next[k] = s5_a_reg[k] * s5_a_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en6) begin
            s6_sq_reg  <= sq_next;
            s6_a_reg   <= s5_a_reg;
            s6_neg_reg <= s5_neg_reg;
        end
    end

    // Stage 7: sum, even shift to [2^60, 2^62), mantissa and seed.
    logic [SUM_W-1:0] sum;
    logic             h;
    logic [MQ_W-1:0]  mq;
    logic [3:0]       seed_idx;
    rs_t              rs_next;
    rs_t              s7_reg;

    always_comb begin
        sum      = SUM_W'(s6_sq_reg[0]) + SUM_W'(s6_sq_reg[1]) + SUM_W'(s6_sq_reg[2]);
        h        = ~|sum[SUM_W-1:SUM_W-2];
        mq       = h ? sum[SUM_W-3:SUM_W-MQ_W-2] : sum[SUM_W-1:SUM_W-MQ_W];
        seed_idx = mq[MQ_W-1] ? {1'b1, mq[30:28]} : {1'b0, mq[29:27]};

        rs_next     = '0;
        rs_next.mq  = mq;
        rs_next.y   = {1'b0, rsqrt_seed(seed_idx), 14'd0};
        rs_next.h   = h;
        rs_next.neg = s6_neg_reg;
        rs_next.a   = s6_a_reg;
    end

    always_ff @(posedge aclk) begin
        if (en7) s7_reg <= rs_next;
    end

    assign out_valid = v7_reg;
    assign out_data  = s7_reg;

    // The largest normalised magnitude has its top bit set.
    a_norm_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && s4_bl_reg != '0) |-> (a_next[0][NORM_W-1] || a_next[1][NORM_W-1]
                                          || a_next[2][NORM_W-1]))
        else $error("normalised magnitudes lost their leading one");

    // A non-zero mantissa lies in [1, 4).
    a_mq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v7_reg && s7_reg.mq != '0) |-> (s7_reg.mq[MQ_W-1] || s7_reg.mq[MQ_W-2]))
        else $error("mantissa below one");

endmodule

`default_nettype wire

FILE: hw/rtl/crg_rsqrt.sv
// ============================================================================
// crg_rsqrt - Newton steps of the reciprocal square root
// Each step takes three stages: y*y, then the correction 3 - m*y^2, then
// half of y times the correction. Everything else rides along unchanged.
// ============================================================================
`default_nettype none

module crg_rsqrt
    import crg_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire rs_t    in_data,
    output logic        out_valid,
    input  wire         out_ready,
    output rs_t         out_data
);

    logic v_reg [RS_STAGES];
    rs_t  d_reg [RS_STAGES];
    logic en    [RS_STAGES];

    for (genvar k = 0; k < RS_STAGES; k++) begin : g_stage
        logic prev_v;
        rs_t  prev;
        rs_t  nxt;
        logic down_ready;

        if (k == 0) begin : g_first
            assign prev_v = in_valid;
            assign prev   = in_data;
        end else begin : g_chain
            assign prev_v = v_reg[k-1];
            assign prev   = d_reg[k-1];
        end

        if (k == RS_STAGES - 1) begin : g_tail
            assign down_ready = out_ready;
        end else begin : g_body
            assign down_ready = en[k+1];
        end

        assign en[k] = !v_reg[k] || down_ready;

        if (k % 3 == 0) begin : g_square
            logic [2*Y_W-1:0] prod;
            assign prod = prev.y * prev.y;
            always_comb begin
                nxt     = prev;
                nxt.acc = prod[2*Y_W-1:30];
            end
        end else if (k % 3 == 1) begin : g_corr
            logic [MQ_W+ACC_W-1:0] prod;
            logic [MQ_W+ACC_W-31:0] p;
            assign prod = prev.mq * prev.acc;
            assign p    = prod[MQ_W+ACC_W-1:30];
            always_comb begin
                nxt = prev;
                if (p < (MQ_W+ACC_W-30)'(THREE_Q30)) begin
                    nxt.acc = ACC_W'((MQ_W+ACC_W-30)'(THREE_Q30) - p);
                end else begin
                    nxt.acc = '0;
                end
            end
        end else begin : g_update
            // For a zero vector the root grows without bound; the magnitudes
            // are zero then, so the truncated value never reaches a result.
            logic [Y_W+ACC_W-1:0] prod;
            assign prod = prev.y * prev.acc;
            always_comb begin
                nxt   = prev;
                nxt.y = prod[Y_W+30:31];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= prev_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) d_reg[k] <= nxt;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[RS_STAGES-1];
    assign out_data  = d_reg[RS_STAGES-1];

    // For a mantissa in [1, 4) the converged root lies close to [2^29, 2^30].
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[RS_STAGES-1] && d_reg[RS_STAGES-1].mq != '0)
        |-> (d_reg[RS_STAGES-1].y >= Y_W'(32'h1000_0000)
             && d_reg[RS_STAGES-1].y <= Y_W'(32'h4010_0000)))
        else $error("reciprocal root out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/crg_out.sv
// ============================================================================
// crg_out - direction scaling, rounding and output register
// Two stages: magnitude times reciprocal root, then rounding, clamping and
// sign. The second stage is the result register of the block.
// ============================================================================
`default_nettype none

module crg_out
    import crg_pkg::*;
(
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire rs_t                     in_data,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [LANES-1:0][DIR_W-1:0]  out_dir
);

    logic en8, en9;
    logic v8_reg, v9_reg;

    assign en9      = !v9_reg || out_ready;
    assign en8      = !v8_reg || en9;
    assign in_ready = en8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else begin
            if (en8) v8_reg <= in_valid;
            if (en9) v9_reg <= v8_reg;
        end
    end

    // Stage 8: products.
    logic [LANES-1:0][PROD_W-1:0] prod_next;
    logic [LANES-1:0][PROD_W-1:0] o1_prod_reg;
    logic [LANES-1:0]             o1_neg_reg;
    logic                         o1_h_reg;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            prod_next[k] = in_data.a[k] * in_data.y;
        end
    end

    always_ff @(posedge aclk) begin
        if (en8) begin
            o1_prod_reg <= prod_next;
            o1_neg_reg  <= in_data.neg;
            o1_h_reg    <= in_data.h;
        end
    end

    // Stage 9: undo the even shift, round to Q1.14, clamp to one, apply sign.
    logic [PROD_W:0]              wide     [LANES];
    logic [PROD_W+1:0]            rounded  [LANES];
    logic [DIR_W:0]               d_raw    [LANES];
    logic [DIR_W-1:0]             d_mag    [LANES];
    logic [LANES-1:0][DIR_W-1:0]  dir_next;
    logic [LANES-1:0][DIR_W-1:0]  o2_dir_reg;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            wide[k]     = o1_h_reg ? {o1_prod_reg[k], 1'b0} : {1'b0, o1_prod_reg[k]};
            rounded[k]  = (PROD_W+2)'(wide[k]) + ((PROD_W+2)'(1) << 45);
            d_raw[k]    = rounded[k][PROD_W+1:46];
            d_mag[k]    = (d_raw[k] > DIR_LIMIT) ? DIR_W'(DIR_LIMIT) : DIR_W'(d_raw[k]);
            dir_next[k] = o1_neg_reg[k] ? DIR_W'(-d_mag[k]) : d_mag[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en9) o2_dir_reg <= dir_next;
    end

    assign out_valid = v9_reg;
    assign out_dir   = o2_dir_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/camera_primary_ray_gen.sv
// ============================================================================
// camera_primary_ray_gen - pinhole camera primary ray generator
// Turns a normalised screen coordinate into a unit ray direction and passes
// the camera position through as the ray origin.
// ============================================================================
//
// One transfer of a (u, v) pair yields one ray. The block is a fully
// pipelined datapath of 9 + 3 * RSQRT_ITERATIONS register stages and
// takes a new coordinate in every clock cycle while the output is not
// stalled, so a pixel stream gets one ray per cycle. The stages come from
// the multiplier chain: three stages to combine the camera basis, four to
// normalise and sum squares, three per Newton step of the reciprocal
// square root, and two to scale and round. Each stage holds its own valid
// bit, so bubbles close up and the input keeps taking transfers while a
// result waits at the output, until all stages hold entries. Configuration
// writes take effect at once and must only be made while no ray is in
// flight; the origin outputs show the position registers directly.
//
`default_nettype none

module camera_primary_ray_gen
    import crg_pkg::*;
(
    input  wire                       aclk,
    input  wire                       aresetn,

    // Configuration write port.
    input  wire                       cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]       cfg_index,
    input  wire [CFG_DATA_W-1:0]      cfg_wdata,

    // Screen coordinate input channel.
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire [COORD_W-1:0]         s_u_coord,
    input  wire [COORD_W-1:0]         s_v_coord,

    // Ray output channel.
    output logic                      m_valid,
    input  wire                       m_ready,
    output logic signed [DIR_W-1:0]   m_dir_x,
    output logic signed [DIR_W-1:0]   m_dir_y,
    output logic signed [DIR_W-1:0]   m_dir_z,
    output logic signed [POS_W-1:0]   m_origin_x,
    output logic signed [POS_W-1:0]   m_origin_y,
    output logic signed [POS_W-1:0]   m_origin_z
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes to an index beyond the list are
    // dropped. Reset gives forward (1,0,0), right (0,0,1), up (0,1,0),
    // both scales at 1.0 and the origin at zero.
    // ------------------------------------------------------------------
    logic [BASIS_W-1:0] forward_reg;
    logic [BASIS_W-1:0] right_reg;
    logic [BASIS_W-1:0] up_reg;
    logic [SCALE_W-1:0] scale_x_reg;
    logic [SCALE_W-1:0] scale_y_reg;
    logic [POS_W-1:0]   pos_x_reg;
    logic [POS_W-1:0]   pos_y_reg;
    logic [POS_W-1:0]   pos_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forward_reg <= 48'h0000_0000_4000;
            right_reg   <= 48'h4000_0000_0000;
            up_reg      <= 48'h0000_4000_0000;
            scale_x_reg <= 24'h01_0000;
            scale_y_reg <= 24'h01_0000;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FORWARD: forward_reg <= cfg_wdata;
                REG_RIGHT:   right_reg   <= cfg_wdata;
                REG_UP:      up_reg      <= cfg_wdata;
                REG_SCALE_X: scale_x_reg <= cfg_wdata[SCALE_W-1:0];
                REG_SCALE_Y: scale_y_reg <= cfg_wdata[SCALE_W-1:0];
                REG_POS_X:   pos_x_reg   <= cfg_wdata[POS_W-1:0];
                REG_POS_Y:   pos_y_reg   <= cfg_wdata[POS_W-1:0];
                REG_POS_Z:   pos_z_reg   <= cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    cfg_t cfg_bus;

    assign cfg_bus = '{fwd:     forward_reg,
                       rgt:     right_reg,
                       up:      up_reg,
                       scale_x: scale_x_reg,
                       scale_y: scale_y_reg};

    // ------------------------------------------------------------------
    // Datapath: front end, normaliser, reciprocal root, output stages.
    // Each boundary is a valid/ready hand-off between stage registers.
    // ------------------------------------------------------------------
    logic front_valid, front_ready;
    vec_t front_data;
    logic norm_valid, norm_ready;
    rs_t  norm_data;
    logic root_valid, root_ready;
    rs_t  root_data;
    logic [LANES-1:0][DIR_W-1:0] dir;

    crg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_bus),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .u_coord   (s_u_coord),
        .v_coord   (s_v_coord),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    crg_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_data  (norm_data)
    );

    crg_rsqrt u_rsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_data   (norm_data),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_data  (root_data)
    );

    crg_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (root_valid),
        .in_ready  (root_ready),
        .in_data   (root_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_dir   (dir)
    );

    assign m_dir_x    = signed'(dir[0]);
    assign m_dir_y    = signed'(dir[1]);
    assign m_dir_z    = signed'(dir[2]);

    // The user must keep the position stable while rays are in flight, so it
    // needs no copy in the pipeline; the block itself does not enforce this.
    assign m_origin_x = signed'(pos_x_reg);
    assign m_origin_y = signed'(pos_y_reg);
    assign m_origin_z = signed'(pos_z_reg);

    // With the result register empty every stage can move, so the input
    // must be open.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input closed although the output stage is empty");

    // Rounded directions never exceed unit length in any lane.
    a_dir_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_dir_x <= 16'sd16384 && m_dir_x >= -16'sd16384
                     && m_dir_y <= 16'sd16384 && m_dir_y >= -16'sd16384
                     && m_dir_z <= 16'sd16384 && m_dir_z >= -16'sd16384))
        else $error("direction component beyond unit range");

endmodule

`default_nettype wire
